// File: hdl/assert_macros.svh
// assertion macros used by the tracker rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, sampled on clock, off during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hdl/rpt_pkg.sv
// types and constants of the reference position tracker
package rpt_pkg;

   localparam int POS_W        = 64;
   localparam int RATIO_W      = 32;
   localparam int FRAME_W      = 13;
   localparam int GAIN_W       = 16;
   localparam int HYST_W       = 16;
   localparam int THRESH_W     = 36;
   localparam int READ_INDEX_W = 48;
   localparam int EVENT_W      = 3;
   localparam int JUMP_W       = 32;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 36;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int INDEX_BITS_DEF = 48;
   localparam int RATIO_FRAC     = 30;
   localparam int GAIN_FRAC      = 16;

   // shared multiplier: frame by ratio, then gain by error magnitude
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 36;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [FRAME_W-1:0]  FRAME_RST  = FRAME_W'(480);
   localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(655);
   localparam logic [HYST_W-1:0]   HYST_RST   = HYST_W'(49152);
   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(31457280);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYST   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH = 2'd3;

   typedef enum logic [EVENT_W-1:0] {
      EV_TRACKED    = 3'd0,
      EV_SLIP_FWD   = 3'd1,
      EV_SLIP_BACK  = 3'd2,
      EV_FIRST_LOCK = 3'd3,
      EV_RELOCK     = 3'd4
   } event_type;

endpackage

// File: hdl/rpt_req_if.sv
// request channel: predicted position and rate ratio
interface rpt_req_if;
   import rpt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   predicted_position;
   logic        [RATIO_W-1:0] rate_ratio;

   modport source (output valid, output predicted_position, output rate_ratio, input ready);
   modport sink   (input valid, input predicted_position, input rate_ratio, output ready);
endinterface

// File: hdl/rpt_rsp_if.sv
// response channel: read index, event code and jump total
interface rpt_rsp_if;
   import rpt_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [READ_INDEX_W-1:0] read_index;
   logic        [EVENT_W-1:0]      event_code;
   logic        [JUMP_W-1:0]       jump_total;

   modport source (output valid, output read_index, output event_code, output jump_total,
                   input ready);
   modport sink   (input valid, input read_index, input event_code, input jump_total,
                   output ready);
endinterface

// File: hdl/rpt_mul.sv
// shared registered multiplier of the tracker sequencer
module rpt_mul (
   input  logic                          clock,
   input  logic [rpt_pkg::MUL_A_W-1:0]   mul_a,
   input  logic [rpt_pkg::MUL_B_W-1:0]   mul_b,
   output logic [rpt_pkg::MUL_P_W-1:0]   product_ff
);
   import rpt_pkg::*;

   always_ff @(posedge clock) begin
      product_ff <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

endmodule

// File: hdl/reference_position_tracker.sv
// Reference position tracker. One request per audio frame carries a predicted
// reference position (signed, FRAC_BITS fraction bits) and a Q2.30 rate ratio;
// one response gives the integer read index, an event code and the running
// jump count. A small sequencer steps each request through one shared 16x36
// registered multiplier and one wide add per cycle: a tracked frame runs the
// advance to slip steps, a relock and the first lock end in the snap steps.
// The request side is not ready while a request is in work; a finished
// response waits in its output register, and the sequencer holds in its last
// step only if the previous response has not yet been taken.
`include "assert_macros.svh"

module reference_position_tracker #(
   parameter int FRAC_BITS  = rpt_pkg::FRAC_BITS_DEF,
   parameter int INDEX_BITS = rpt_pkg::INDEX_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rpt_req_if.sink                         req_ch,
   rpt_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [rpt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rpt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rpt_pkg::*;

   localparam int ADV_SHIFT = RATIO_FRAC - FRAC_BITS;
   localparam logic [MUL_P_W-1:0] ADV_HALF  = MUL_P_W'(1) << (ADV_SHIFT - 1);
   localparam logic [MUL_P_W-1:0] PULL_HALF = MUL_P_W'(1) << (GAIN_FRAC - 1);
   localparam logic [POS_W-1:0]   SNAP_HALF = POS_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADV,
      S_ERR,
      S_CHK,
      S_PULL,
      S_OFF,
      S_SLIP,
      S_SNAP_MAG,
      S_SNAP_RND,
      S_SNAP_NEG,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic                     locked_ff, locked_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [INDEX_BITS-1:0]    idx_ff, idx_in;
   logic [JUMP_W-1:0]        jump_ff, jump_in;
   logic [FRAME_W-1:0]       frame_ff, frame_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [HYST_W-1:0]        hyst_ff, hyst_in;
   logic [THRESH_W-1:0]      thresh_ff, thresh_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [POS_W-1:0]         pred_ff, pred_in;
   logic [POS_W-1:0]         work_ff, work_in;
   logic                     ovf_ff, ovf_in;
   event_type                event_ff, event_in;
   logic [READ_INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   event_type                rsp_event_ff, rsp_event_in;
   logic [JUMP_W-1:0]        rsp_jump_ff, rsp_jump_in;

   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [MUL_P_W-1:0]       mul_p;

   logic [POS_W-1:0]         idx_sx;
   logic [POS_W-1:0]         work_mag;
   logic [POS_W-1:0]         err;
   logic [MUL_P_W-1:0]       adv_sum;
   logic [MUL_P_W-1:0]       pull_sum;

   rpt_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (mul_p)
   );

   assign idx_sx   = {{(POS_W-INDEX_BITS){idx_ff[INDEX_BITS-1]}}, idx_ff};
   assign work_mag = work_ff[POS_W-1] ? (POS_W'(0) - work_ff) : work_ff;
   assign err      = pred_ff - pos_ff;
   assign adv_sum  = mul_p + ADV_HALF;
   assign pull_sum = mul_p + PULL_HALF;

   // multiplier operands: frame by ratio at request, gain by error magnitude at check
   always_comb begin
      if (state_ff == S_CHK) begin
         mul_a = MUL_A_W'(gain_ff);
         mul_b = work_mag[MUL_B_W-1:0];
      end else begin
         mul_a = MUL_A_W'(frame_ff);
         mul_b = MUL_B_W'(req_ch.rate_ratio);
      end
   end

   always_comb begin
      state_in     = state_ff;
      locked_in    = locked_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      jump_in      = jump_ff;
      frame_in     = frame_ff;
      gain_in      = gain_ff;
      hyst_in      = hyst_ff;
      thresh_in    = thresh_ff;
      pred_in      = pred_ff;
      work_in      = work_ff;
      ovf_in       = ovf_ff;
      event_in     = event_ff;
      rsp_index_in = rsp_index_ff;
      rsp_event_in = rsp_event_ff;
      rsp_jump_in  = rsp_jump_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;

      if (csr_we) begin
         case (csr_index)
            CSR_FRAME:  frame_in  = csr_data[FRAME_W-1:0];
            CSR_GAIN:   gain_in   = csr_data[GAIN_W-1:0];
            CSR_HYST:   hyst_in   = csr_data[HYST_W-1:0];
            CSR_THRESH: thresh_in = csr_data[THRESH_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               pred_in = req_ch.predicted_position;
               if (locked_ff) begin
                  state_in = S_ADV;
               end else begin
                  event_in = EV_FIRST_LOCK;
                  state_in = S_SNAP_MAG;
               end
            end
         end
         S_ADV: begin
            pos_in   = pos_ff + POS_W'(adv_sum >> ADV_SHIFT);
            idx_in   = idx_ff + INDEX_BITS'(frame_ff);
            state_in = S_ERR;
         end
         S_ERR: begin
            work_in  = err;
            ovf_in   = ((pred_ff[POS_W-1] ^ pos_ff[POS_W-1])
                        & (pred_ff[POS_W-1] ^ err[POS_W-1]));
            state_in = S_CHK;
         end
         S_CHK: begin
            if (ovf_ff || work_mag >= POS_W'(thresh_ff)) begin
               jump_in  = jump_ff + JUMP_W'(1);
               event_in = EV_RELOCK;
               state_in = S_SNAP_MAG;
            end else begin
               state_in = S_PULL;
            end
         end
         S_PULL: begin
            // pull toward prediction, magnitude rounded half away from zero
            if (work_ff[POS_W-1]) begin
               pos_in = pos_ff - POS_W'(pull_sum >> GAIN_FRAC);
            end else begin
               pos_in = pos_ff + POS_W'(pull_sum >> GAIN_FRAC);
            end
            state_in = S_OFF;
         end
         S_OFF: begin
            work_in  = pos_ff - (idx_sx << FRAC_BITS);
            state_in = S_SLIP;
         end
         S_SLIP: begin
            if (work_mag > POS_W'(hyst_ff)) begin
               if (work_ff[POS_W-1]) begin
                  idx_in   = idx_ff - INDEX_BITS'(1);
                  event_in = EV_SLIP_BACK;
               end else begin
                  idx_in   = idx_ff + INDEX_BITS'(1);
                  event_in = EV_SLIP_FWD;
               end
               jump_in = jump_ff + JUMP_W'(1);
            end else begin
               event_in = EV_TRACKED;
            end
            state_in = S_DONE;
         end
         S_SNAP_MAG: begin
            work_in   = pred_ff[POS_W-1] ? (POS_W'(0) - pred_ff) : pred_ff;
            pos_in    = pred_ff;
            locked_in = 1'b1;
            state_in  = S_SNAP_RND;
         end
         S_SNAP_RND: begin
            work_in  = (work_ff + SNAP_HALF) >> FRAC_BITS;
            state_in = S_SNAP_NEG;
         end
         S_SNAP_NEG: begin
            if (pred_ff[POS_W-1]) begin
               idx_in = INDEX_BITS'(POS_W'(0) - work_ff);
            end else begin
               idx_in = work_ff[INDEX_BITS-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_index_in = idx_sx[READ_INDEX_W-1:0];
               rsp_event_in = event_ff;
               rsp_jump_in  = jump_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         locked_ff    <= 1'b0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         jump_ff      <= '0;
         frame_ff     <= FRAME_RST;
         gain_ff      <= GAIN_RST;
         hyst_ff      <= HYST_RST;
         thresh_ff    <= THRESH_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         locked_ff    <= locked_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         jump_ff      <= jump_in;
         frame_ff     <= frame_in;
         gain_ff      <= gain_in;
         hyst_ff      <= hyst_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pred_ff      <= pred_in;
      work_ff      <= work_in;
      ovf_ff       <= ovf_in;
      event_ff     <= event_in;
      rsp_index_ff <= rsp_index_in;
      rsp_event_ff <= rsp_event_in;
      rsp_jump_ff  <= rsp_jump_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_index = rsp_index_ff;
   assign rsp_ch.event_code = rsp_event_ff;
   assign rsp_ch.jump_total = rsp_jump_ff;

   `ASSERT_NEXT(a_busy_after_request, req_ch.valid && req_ch.ready, !req_ch.ready)
   `ASSERT_NEXT(a_lock_holds, locked_ff, locked_ff)
   `ASSERT_IMPLIES(a_response_from_done, rsp_valid_in && !rsp_valid_ff, state_ff == S_DONE)

endmodule

// File: dv/reference_position_tracker_tb.sv
// testbench of the reference position tracker: directed and random frames
module reference_position_tracker_tb;
   import rpt_pkg::*;

   localparam int FRAC  = FRAC_BITS_DEF;
   localparam int IDX_W = INDEX_BITS_DEF;

   typedef struct packed {
      logic [READ_INDEX_W-1:0] read_index;
      event_type               ev;
      logic [JUMP_W-1:0]       jumps;
   } frame_outcome_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   rpt_req_if req_ch ();
   rpt_rsp_if rsp_ch ();

   reference_position_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // register copies
   logic [FRAME_W-1:0]  cfg_frame  = FRAME_RST;
   logic [GAIN_W-1:0]   cfg_gain   = GAIN_RST;
   logic [HYST_W-1:0]   cfg_hyst   = HYST_RST;
   logic [THRESH_W-1:0] cfg_thresh = THRESH_RST;

   // tracker state as the block should hold it
   logic              tr_locked = 1'b0;
   logic [POS_W-1:0]  tr_pos    = '0;
   logic [IDX_W-1:0]  tr_index  = '0;
   logic [JUMP_W-1:0] tr_jumps  = '0;

   frame_outcome_type awaited_outcomes[$];
   int                mismatch_count  = 0;
   int                frames_sent     = 0;
   int                outcomes_seen   = 0;
   int                event_tally[5]  = '{default: 0};
   bit                stall_enable    = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   // snap to the prediction, index rounded half away from zero
   function automatic void snap_to(input logic [POS_W-1:0] pred);
      logic [63:0] r;
      r = (magnitude(pred) + (64'd1 << (FRAC - 1))) >> FRAC;
      if (pred[63]) r = -r;
      tr_locked = 1'b1;
      tr_pos    = pred;
      tr_index  = r[IDX_W-1:0];
   endfunction

   function automatic frame_outcome_type track_frame(input logic [POS_W-1:0] pred,
                                                     input logic [RATIO_W-1:0] ratio);
      logic [63:0]       prod, adv, err, emag, pull, off;
      logic              ovf;
      frame_outcome_type res;
      res.ev = EV_TRACKED;
      if (!tr_locked) begin
         snap_to(pred);
         res.ev = EV_FIRST_LOCK;
      end else begin
         prod     = 64'(cfg_frame) * 64'(ratio);
         adv      = (prod + (64'd1 << (RATIO_FRAC - FRAC - 1))) >> (RATIO_FRAC - FRAC);
         tr_pos   = tr_pos + adv;
         tr_index = tr_index + IDX_W'(cfg_frame);
         err      = pred - tr_pos;
         ovf      = (pred[63] ^ tr_pos[63]) & (pred[63] ^ err[63]);
         emag     = magnitude(err);
         if (!ovf && emag < 64'(cfg_thresh)) begin
            pull   = (64'(cfg_gain) * emag + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
            tr_pos = err[63] ? tr_pos - pull : tr_pos + pull;
            off    = tr_pos - (64'(signed'(tr_index)) << FRAC);
            if (magnitude(off) > 64'(cfg_hyst)) begin
               if (off[63]) begin
                  tr_index = tr_index - IDX_W'(1);
                  res.ev   = EV_SLIP_BACK;
               end else begin
                  tr_index = tr_index + IDX_W'(1);
                  res.ev   = EV_SLIP_FWD;
               end
               tr_jumps = tr_jumps + JUMP_W'(1);
            end
         end else begin
            tr_jumps = tr_jumps + JUMP_W'(1);
            snap_to(pred);
            res.ev = EV_RELOCK;
         end
      end
      res.read_index = READ_INDEX_W'(tr_index);
      res.jumps      = tr_jumps;
      return res;
   endfunction

   task automatic send_frame(input logic [POS_W-1:0] pred, input logic [RATIO_W-1:0] ratio);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.predicted_position <= pred;
      req_ch.rate_ratio         <= ratio;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      awaited_outcomes.push_back(track_frame(pred, ratio));
      frames_sent++;
   endtask

   // drop valid and let every outstanding request complete; report any that never do
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      while (awaited_outcomes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (awaited_outcomes.size() != 0) begin
         $error("%0d responses never arrived", awaited_outcomes.size());
         mismatch_count += awaited_outcomes.size();
         awaited_outcomes.delete();
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME:  cfg_frame  = value[FRAME_W-1:0];
         CSR_GAIN:   cfg_gain   = value[GAIN_W-1:0];
         CSR_HYST:   cfg_hyst   = value[HYST_W-1:0];
         CSR_THRESH: cfg_thresh = value[THRESH_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [FRAME_W-1:0] frame, input logic [GAIN_W-1:0] gain,
                                 input logic [HYST_W-1:0] hyst, input logic [THRESH_W-1:0] thresh);
      wait_idle();
      write_csr(CSR_FRAME, CSR_DATA_W'(frame));
      write_csr(CSR_GAIN, CSR_DATA_W'(gain));
      write_csr(CSR_HYST, CSR_DATA_W'(hyst));
      write_csr(CSR_THRESH, CSR_DATA_W'(thresh));
   endtask

   // frames that follow an ideal clock, with jitter, noise, jumps and some garbage requests
   task automatic run_tracking(input int n, input logic [RATIO_W-1:0] ratio_nom,
                               input logic [POS_W-1:0] start_pos, input int noise_pct);
      logic [POS_W-1:0] ideal;
      ideal = start_pos;
      for (int i = 0; i < n; i++) begin
         int unsigned      dice;
         logic [RATIO_W-1:0] ratio;
         dice = $urandom_range(0, 99);
         if (dice < noise_pct) begin
            send_frame({$urandom, $urandom}, $urandom);
         end else begin
            ratio = ratio_nom + $urandom_range(0, 2000) - 32'd1000;
            ideal = ideal + ((64'(cfg_frame) * 64'(ratio_nom)) >> (RATIO_FRAC - FRAC));
            if (dice >= 98)
               ideal = ideal + (64'($urandom_range(0, 32'h0FFF_FFFF)) << 4);
            else if (dice == 97)
               ideal = ideal - (64'($urandom_range(0, 32'h0FFF_FFFF)) << 4);
            send_frame(ideal + 64'($urandom_range(0, 65535)) - 64'd32768, ratio);
         end
      end
   endtask

   task automatic test_first_lock();
      // 2.5 samples rounds away from zero to index 3
      send_frame(64'h0000_0000_0002_8000, 32'h4000_0000);
   endtask

   task automatic test_tracking_slips();
      send_frame(64'h0000_0000_01E2_8000, 32'h4000_0000);
      send_frame(64'h0000_0000_03C4_0000, 32'h4033_3333);
      send_frame(64'h0000_0000_05A2_8000, 32'h3FCC_CCCD);
      send_frame(64'h0000_0000_05A2_8000, 32'h0000_0000);
      send_frame(64'h0000_0000_0D22_8000, 32'hFFFF_FFFF);
   endtask

   task automatic test_relock_overflow();
      send_frame(64'h0000_4000_0000_0000, 32'h4000_0000);
      // error does not fit in 64 bits either way
      send_frame(64'h8000_0000_0000_0000, 32'h4000_0000);
      send_frame(64'h7FFF_FFFF_FFFF_FFFF, 32'h4000_0000);
      send_frame(64'h0000_0000_0000_0000, 32'h4000_0000);
      // minus 2.5 samples snaps to index -3
      send_frame(64'hFFFF_FFFF_FFFD_8000, 32'h4000_0000);
      send_frame(64'h0000_0000_01DD_8000, 32'h4000_0000);
   endtask

   task automatic test_register_extremes();
      apply_settings(FRAME_RST, GAIN_RST, HYST_RST, '0);
      send_frame(64'h0000_1234_5678_9ABC, 32'h4000_0000);
      send_frame(64'h0000_1234_5678_9ABC, 32'h4000_0000);
      // zero frame: nothing advances
      apply_settings('0, GAIN_RST, HYST_RST, THRESH_RST);
      send_frame(64'h0000_1234_5678_9ABC, 32'h4000_0000);
      send_frame(64'h0000_1234_567A_0000, 32'h7FFF_FFFF);
      apply_settings(FRAME_W'(1), '1, '0, THRESH_RST);
      send_frame(64'h0000_1234_567C_4CCC, 32'h4000_0000);
      send_frame(64'h0000_1234_567B_0000, 32'h2000_0000);
      apply_settings('1, '0, '1, '1);
      send_frame(64'h0000_1234_767B_0000, 32'h4000_0000);
      send_frame(64'h0000_1234_F67B_0000, 32'hFFFF_FFFF);
      apply_settings(FRAME_RST, GAIN_RST, HYST_RST, THRESH_RST);
   endtask

   task automatic test_random_tracking();
      run_tracking(200, 32'h4003_4690, 64'h0, 5);
      // position wraps past the top of the range
      apply_settings(FRAME_W'(4096), '1, '0, '1);
      run_tracking(200, 32'h3FF0_0000, 64'h7FFF_FFFA_0000_0000, 5);
      apply_settings(FRAME_W'(1), '0, '1, THRESH_W'(131072));
      run_tracking(200, 32'h6000_0000, 64'hFFFF_FF00_0000_0000, 5);
      apply_settings('1, GAIN_W'(32768), HYST_W'(32768), '1);
      run_tracking(150, 32'hFFFF_F000, 64'h0000_0100_0000_0000, 5);
      apply_settings('0, GAIN_W'($urandom), HYST_W'($urandom),
                     {4'($urandom_range(0, 15)), $urandom});
      run_tracking(100, $urandom, {$urandom, $urandom}, 10);
      apply_settings(FRAME_RST, GAIN_RST, HYST_RST, '0);
      run_tracking(50, 32'h4000_0000, 64'h0, 5);
      for (int p = 0; p < 3; p++) begin
         apply_settings(FRAME_W'($urandom_range(1, 4096)), GAIN_W'($urandom),
                        HYST_W'($urandom), {4'($urandom_range(0, 15)), $urandom});
         run_tracking(100, 32'h4000_0000 + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                      {$urandom, $urandom}, 5);
      end
   endtask

   task automatic test_final_unstalled();
      apply_settings(FRAME_RST, GAIN_RST, HYST_RST, THRESH_RST);
      stall_enable = 1'b0;
      run_tracking(150, 32'h3FFE_0000, 64'h0000_0000_1000_0000, 5);
   endtask

   // response side back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (stall_enable && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_rsp
      frame_outcome_type exp;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            exp = awaited_outcomes.pop_front();
            outcomes_seen++;
            if (rsp_ch.event_code < 5) event_tally[rsp_ch.event_code]++;
            if (rsp_ch.read_index !== exp.read_index) begin
               $error("read_index: expected %0h, got %0h", exp.read_index, rsp_ch.read_index);
               mismatch_count++;
            end
            if (rsp_ch.event_code !== exp.ev) begin
               $error("event_code: expected %0d, got %0d", exp.ev, rsp_ch.event_code);
               mismatch_count++;
            end
            if (rsp_ch.jump_total !== exp.jumps) begin
               $error("jump_total: expected %0d, got %0d", exp.jumps, rsp_ch.jump_total);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset                     <= 1'b1;
      req_ch.valid              <= 1'b0;
      req_ch.predicted_position <= '0;
      req_ch.rate_ratio         <= '0;
      csr_we                    <= 1'b0;
      csr_index                 <= '0;
      csr_data                  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_lock();
      test_tracking_slips();
      test_relock_overflow();
      test_register_extremes();
      test_random_tracking();
      test_final_unstalled();
      wait_idle();
      $display("frames sent %0d, responses checked %0d", frames_sent, outcomes_seen);
      $display("tracked %0d, slip fwd %0d, slip back %0d, first lock %0d, relock %0d",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3], event_tally[4]);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rpt_pkg.sv
hdl/rpt_req_if.sv
hdl/rpt_rsp_if.sv
hdl/rpt_mul.sv
hdl/reference_position_tracker.sv
dv/reference_position_tracker_tb.sv
